[design/gpioed_pkg.sv]
// ----------------------------------------------------------------------------
// gpioed_pkg: shared types and constants of the GPIO edge-detect controller
// Request kinds, register codes, the offset decode table, the wake-capable
// pin sets and the transaction structs passed between the modules.
// ----------------------------------------------------------------------------
package gpioed_pkg;

   localparam int BANKS_DEFAULT = 4;
   localparam int BANK_W        = 32;
   localparam int OFFSET_W      = 12;
   localparam int LINE_W        = 7;
   localparam int NUM_LINES_W   = 8;
   localparam int REG_ROWS      = 9;
   localparam int TABLE_BANKS   = 4;

   localparam logic [NUM_LINES_W-1:0] NUM_LINES_RESET = 8'd128;
   localparam logic [OFFSET_W-1:0]    WINDOW_END      = 12'h200;

   typedef enum logic [1:0] {
      REQ_READ  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_EVENT = 2'd2
   } req_kind_type;

   typedef enum logic [3:0] {
      R_NONE  = 4'd0,
      R_LEVEL = 4'd1,
      R_SET   = 4'd2,
      R_CLR   = 4'd3,
      R_DIR   = 4'd4,
      R_RISE  = 4'd5,
      R_FALL  = 4'd6,
      R_EDGE  = 4'd7,
      R_AFL   = 4'd8,
      R_AFU   = 4'd9
   } reg_code_type;

   // Row r holds the offsets of register code r+1 for banks 0 to 3.
   localparam logic [OFFSET_W-1:0] ADDR_TABLE [REG_ROWS][TABLE_BANKS] = '{
      '{12'h000, 12'h004, 12'h008, 12'h100},
      '{12'h018, 12'h01c, 12'h020, 12'h118},
      '{12'h024, 12'h028, 12'h02c, 12'h124},
      '{12'h00c, 12'h010, 12'h014, 12'h10c},
      '{12'h030, 12'h034, 12'h038, 12'h130},
      '{12'h03c, 12'h040, 12'h044, 12'h13c},
      '{12'h048, 12'h04c, 12'h050, 12'h148},
      '{12'h054, 12'h05c, 12'h064, 12'h06c},
      '{12'h058, 12'h060, 12'h068, 12'h070}
   };

   localparam logic [BANK_W-1:0] WAKE_SET [TABLE_BANKS] = '{
      32'h8003fe1b, 32'h002001fc, 32'hec080000, 32'h0012007f
   };

   typedef struct packed {
      logic [1:0]          req_type;
      logic [OFFSET_W-1:0] offset;
      logic [BANK_W-1:0]   wdata;
      logic [LINE_W-1:0]   pin_line;
      logic                pin_level;
      logic                cpu_halted;
   } req_item_type;

   typedef struct packed {
      logic [BANK_W-1:0] rdata;
      logic              bad_access;
      logic              irq_pin0;
      logic              irq_pin1;
      logic              irq_other;
      logic              wake_request;
      logic [1:0]        changed_bank;
      logic [BANK_W-1:0] changed_mask;
      logic [BANK_W-1:0] driven_levels;
   } rsp_item_type;

   typedef struct packed {
      logic         hit;
      reg_code_type code;
      logic [1:0]   bank;
   } dec_type;

endpackage

[design/gpioed_req_if.sv]
// ----------------------------------------------------------------------------
// gpioed_req_if: request channel
// Carries bus reads, bus writes and pin level events with valid and ready.
// ----------------------------------------------------------------------------
interface gpioed_req_if;
   import gpioed_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          req_type;
   logic [OFFSET_W-1:0] offset;
   logic [BANK_W-1:0]   wdata;
   logic [LINE_W-1:0]   pin_line;
   logic                pin_level;
   logic                cpu_halted;

   modport source (
      output valid, req_type, offset, wdata, pin_line, pin_level, cpu_halted,
      input  ready
   );

   modport sink (
      input  valid, req_type, offset, wdata, pin_line, pin_level, cpu_halted,
      output ready
   );
endinterface

[design/gpioed_rsp_if.sv]
// ----------------------------------------------------------------------------
// gpioed_rsp_if: response channel
// Carries one result transaction per request with valid and ready.
// ----------------------------------------------------------------------------
interface gpioed_rsp_if;
   import gpioed_pkg::*;

   logic              valid;
   logic              ready;
   logic [BANK_W-1:0] rdata;
   logic              bad_access;
   logic              irq_pin0;
   logic              irq_pin1;
   logic              irq_other;
   logic              wake_request;
   logic [1:0]        changed_bank;
   logic [BANK_W-1:0] changed_mask;
   logic [BANK_W-1:0] driven_levels;

   modport source (
      output valid, rdata, bad_access, irq_pin0, irq_pin1, irq_other, wake_request,
             changed_bank, changed_mask, driven_levels,
      input  ready
   );

   modport sink (
      input  valid, rdata, bad_access, irq_pin0, irq_pin1, irq_other, wake_request,
             changed_bank, changed_mask, driven_levels,
      output ready
   );
endinterface

[design/gpioed_csr_if.sv]
// ----------------------------------------------------------------------------
// gpioed_csr_if: configuration write channel
// Carries the write data of the line-count register with valid and ready.
// ----------------------------------------------------------------------------
interface gpioed_csr_if;
   import gpioed_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [NUM_LINES_W-1:0] data;

   modport source (
      output valid, data,
      input  ready
   );

   modport sink (
      input  valid, data,
      output ready
   );
endinterface

[design/gpioed_decode.sv]
// ----------------------------------------------------------------------------
// gpioed_decode: register offset decoder
// Looks a window offset up in the fixed table and returns code and bank.
// ----------------------------------------------------------------------------
module gpioed_decode (
   input  logic [gpioed_pkg::OFFSET_W-1:0] offset,
   output gpioed_pkg::dec_type             dec
);
   import gpioed_pkg::*;

   always_comb begin
      dec = '{hit: 1'b0, code: R_NONE, bank: 2'd0};
      for (int r = 0; r < REG_ROWS; r++) begin
         for (int b = 0; b < TABLE_BANKS; b++) begin
            if (!dec.hit && offset == ADDR_TABLE[r][b]) begin
               dec.hit  = 1'b1;
               dec.code = reg_code_type'(4'(r + 1));
               dec.bank = 2'(b);
            end
         end
      end
   end
endmodule

[design/gpioed_core.sv]
// ----------------------------------------------------------------------------
// gpioed_core: bank registers and per-transaction update logic
// Holds the pin, output, direction, enable, status and alternate-function
// words of every bank and computes the result of one request transaction.
// ----------------------------------------------------------------------------
module gpioed_core #(
   parameter int BANKS = gpioed_pkg::BANKS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               fire,
   input  gpioed_pkg::req_item_type           item,
   input  gpioed_pkg::dec_type                dec,
   input  logic [gpioed_pkg::NUM_LINES_W-1:0] num_lines,
   output gpioed_pkg::rsp_item_type           result
);
   import gpioed_pkg::*;

   logic [BANK_W-1:0] input_ff  [BANKS];
   logic [BANK_W-1:0] input_in  [BANKS];
   logic [BANK_W-1:0] output_ff [BANKS];
   logic [BANK_W-1:0] output_in [BANKS];
   logic [BANK_W-1:0] dir_ff    [BANKS];
   logic [BANK_W-1:0] dir_in    [BANKS];
   logic [BANK_W-1:0] rise_ff   [BANKS];
   logic [BANK_W-1:0] rise_in   [BANKS];
   logic [BANK_W-1:0] fall_ff   [BANKS];
   logic [BANK_W-1:0] fall_in   [BANKS];
   logic [BANK_W-1:0] status_ff [BANKS];
   logic [BANK_W-1:0] status_in [BANKS];
   logic [BANK_W-1:0] afl_ff    [BANKS];
   logic [BANK_W-1:0] afl_in    [BANKS];
   logic [BANK_W-1:0] afu_ff    [BANKS];
   logic [BANK_W-1:0] afu_in    [BANKS];
   logic [BANK_W-1:0] last_ff   [BANKS];
   logic [BANK_W-1:0] last_in   [BANKS];

   logic              reg_oob;
   logic              pin_oob;
   logic [1:0]        pin_bank;
   logic [BANK_W-1:0] pin_mask;
   logic              drv;
   logic [BANK_W-1:0] drv_now;
   logic              other;

   assign reg_oob  = {1'b0, dec.bank} >= 3'(BANKS);
   assign pin_bank = item.pin_line[LINE_W-1:LINE_W-2];
   assign pin_mask = 32'd1 << item.pin_line[4:0];
   assign pin_oob  = ({1'b0, item.pin_line} >= num_lines) || ({1'b0, pin_bank} >= 3'(BANKS));

   always_comb begin
      for (int b = 0; b < BANKS; b++) begin
         input_in[b]  = input_ff[b];
         output_in[b] = output_ff[b];
         dir_in[b]    = dir_ff[b];
         rise_in[b]   = rise_ff[b];
         fall_in[b]   = fall_ff[b];
         status_in[b] = status_ff[b];
         afl_in[b]    = afl_ff[b];
         afu_in[b]    = afu_ff[b];
         last_in[b]   = last_ff[b];
      end
      result  = '0;
      drv     = 1'b0;
      drv_now = '0;

      if (fire) begin
         case (req_kind_type'(item.req_type))
            REQ_READ: begin
               if (item.offset < WINDOW_END) begin
                  if (!dec.hit || reg_oob) begin
                     result.bad_access = 1'b1;
                  end else begin
                     for (int b = 0; b < BANKS; b++) begin
                        if (2'(b) == dec.bank) begin
                           case (dec.code)
                              R_LEVEL: result.rdata = (output_ff[b] & dir_ff[b]) |
                                                      (input_ff[b] & ~dir_ff[b]);
                              R_DIR:   result.rdata = dir_ff[b];
                              R_RISE:  result.rdata = rise_ff[b];
                              R_FALL:  result.rdata = fall_ff[b];
                              R_EDGE:  result.rdata = status_ff[b];
                              R_AFL:   result.rdata = afl_ff[b];
                              R_AFU:   result.rdata = afu_ff[b];
                              default: result.bad_access = 1'b1;
                           endcase
                        end
                     end
                  end
               end
            end
            REQ_WRITE: begin
               if (item.offset < WINDOW_END) begin
                  if (!dec.hit || reg_oob) begin
                     result.bad_access = 1'b1;
                  end else begin
                     for (int b = 0; b < BANKS; b++) begin
                        if (2'(b) == dec.bank) begin
                           case (dec.code)
                              R_DIR: begin
                                 dir_in[b] = item.wdata;
                                 drv       = 1'b1;
                              end
                              R_SET: begin
                                 output_in[b] = output_ff[b] | item.wdata;
                                 drv          = 1'b1;
                              end
                              R_CLR: begin
                                 output_in[b] = output_ff[b] & ~item.wdata;
                                 drv          = 1'b1;
                              end
                              R_RISE:  rise_in[b]   = item.wdata;
                              R_FALL:  fall_in[b]   = item.wdata;
                              R_EDGE:  status_in[b] = status_ff[b] & ~item.wdata;
                              R_AFL:   afl_in[b]    = item.wdata;
                              R_AFU:   afu_in[b]    = item.wdata;
                              default: result.bad_access = 1'b1;
                           endcase
                           if (drv) begin
                              drv_now              = output_in[b] & dir_in[b];
                              result.changed_bank  = dec.bank;
                              result.changed_mask  = last_ff[b] ^ drv_now;
                              result.driven_levels = drv_now;
                              last_in[b]           = drv_now;
                           end
                        end
                     end
                  end
               end
            end
            REQ_EVENT: begin
               if (pin_oob) begin
                  result.bad_access = 1'b1;
               end else begin
                  for (int b = 0; b < BANKS; b++) begin
                     if (2'(b) == pin_bank) begin
                        if (item.pin_level) begin
                           status_in[b] = status_ff[b] |
                                          (rise_ff[b] & pin_mask & ~input_ff[b] & ~dir_ff[b]);
                           input_in[b]  = input_ff[b] | pin_mask;
                        end else begin
                           status_in[b] = status_ff[b] |
                                          (fall_ff[b] & pin_mask & input_ff[b] & ~dir_ff[b]);
                           input_in[b]  = input_ff[b] & ~pin_mask;
                        end
                        if (item.cpu_halted && |(pin_mask & ~dir_ff[b] & WAKE_SET[b])) begin
                           result.wake_request = 1'b1;
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
      end

      // Interrupt levels follow the status after this transaction.
      other = |status_in[0][BANK_W-1:2];
      for (int b = 1; b < BANKS; b++) begin
         other = other | (|status_in[b]);
      end
      result.irq_pin0  = status_in[0][0];
      result.irq_pin1  = status_in[0][1];
      result.irq_other = other;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < BANKS; b++) begin
            input_ff[b]  <= '0;
            output_ff[b] <= '0;
            dir_ff[b]    <= '0;
            rise_ff[b]   <= '0;
            fall_ff[b]   <= '0;
            status_ff[b] <= '0;
            afl_ff[b]    <= '0;
            afu_ff[b]    <= '0;
            last_ff[b]   <= '0;
         end
      end else begin
         for (int b = 0; b < BANKS; b++) begin
            input_ff[b]  <= input_in[b];
            output_ff[b] <= output_in[b];
            dir_ff[b]    <= dir_in[b];
            rise_ff[b]   <= rise_in[b];
            fall_ff[b]   <= fall_in[b];
            status_ff[b] <= status_in[b];
            afl_ff[b]    <= afl_in[b];
            afu_ff[b]    <= afu_in[b];
            last_ff[b]   <= last_in[b];
         end
      end
   end
endmodule

[design/gpio_controller_edge_detect.sv]
// ----------------------------------------------------------------------------
// gpio_controller_edge_detect: banked GPIO controller with edge interrupts
// A request is held in the input register, and its result is registered into
// the response register until taken. Throughput: one transaction per cycle
// while the response sink is ready, set by the single update pass between the
// two registers. Synchronous reset clears all bank registers and sets the
// line count to 128; no clearing pass is needed.
// ----------------------------------------------------------------------------
module gpio_controller_edge_detect #(
   parameter int BANKS = gpioed_pkg::BANKS_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   gpioed_req_if.sink   req_if,
   gpioed_rsp_if.source rsp_if,
   gpioed_csr_if.sink   csr_if
);
   import gpioed_pkg::*;

   // Input register: holds the request transaction being processed.
   req_item_type           req_ff;
   req_item_type           req_in;
   logic                   req_valid_ff;
   logic                   req_valid_in;

   // Response register: holds a finished result until the sink takes it.
   rsp_item_type           rsp_ff;
   rsp_item_type           rsp_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;

   logic [NUM_LINES_W-1:0] num_lines_ff;
   logic [NUM_LINES_W-1:0] num_lines_in;

   dec_type                dec;
   rsp_item_type           core_result;
   logic                   advance;

   // The held request moves on, and commits its state changes, whenever the
   // response register is empty or is being emptied in the same cycle.
   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !req_valid_ff || advance;
   assign csr_if.ready = 1'b1;

   always_comb begin
      req_in       = req_ff;
      req_valid_in = req_valid_ff;
      if (req_if.valid && req_if.ready) begin
         req_in.req_type   = req_if.req_type;
         req_in.offset     = req_if.offset;
         req_in.wdata      = req_if.wdata;
         req_in.pin_line   = req_if.pin_line;
         req_in.pin_level  = req_if.pin_level;
         req_in.cpu_halted = req_if.cpu_halted;
         req_valid_in      = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_in       = core_result;
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      num_lines_in = num_lines_ff;
      if (csr_if.valid && csr_if.ready) begin
         num_lines_in = csr_if.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         num_lines_ff <= NUM_LINES_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         num_lines_ff <= num_lines_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   gpioed_decode u_decode (
      .offset (req_ff.offset),
      .dec    (dec)
   );

   gpioed_core #(
      .BANKS (BANKS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .item      (req_ff),
      .dec       (dec),
      .num_lines (num_lines_ff),
      .result    (core_result)
   );

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.rdata         = rsp_ff.rdata;
   assign rsp_if.bad_access    = rsp_ff.bad_access;
   assign rsp_if.irq_pin0      = rsp_ff.irq_pin0;
   assign rsp_if.irq_pin1      = rsp_ff.irq_pin1;
   assign rsp_if.irq_other     = rsp_ff.irq_other;
   assign rsp_if.wake_request  = rsp_ff.wake_request;
   assign rsp_if.changed_bank  = rsp_ff.changed_bank;
   assign rsp_if.changed_mask  = rsp_ff.changed_mask;
   assign rsp_if.driven_levels = rsp_ff.driven_levels;
endmodule

[tb/sv/gpioed_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gpioed_checker: response predictor and scoreboard of the GPIO controller
// Watches the request, response and line-count channels, keeps its own image
// of the bank registers, predicts one response per request transaction and
// compares every accepted response against the oldest prediction.
// ----------------------------------------------------------------------------
module gpioed_checker (
   input  logic  clock,
   input  logic  reset,
   gpioed_req_if req_if,
   gpioed_rsp_if rsp_if,
   gpioed_csr_if csr_if,
   output int    pending,
   output int    fail_count
);
   import gpioed_pkg::*;

   localparam int NBANKS     = 4;

   // Register offsets: row r is register code r+1, column is the bank.
   localparam logic [11:0] REG_OFFSETS [9][4] = '{
      '{12'h000, 12'h004, 12'h008, 12'h100},
      '{12'h018, 12'h01c, 12'h020, 12'h118},
      '{12'h024, 12'h028, 12'h02c, 12'h124},
      '{12'h00c, 12'h010, 12'h014, 12'h10c},
      '{12'h030, 12'h034, 12'h038, 12'h130},
      '{12'h03c, 12'h040, 12'h044, 12'h13c},
      '{12'h048, 12'h04c, 12'h050, 12'h148},
      '{12'h054, 12'h05c, 12'h064, 12'h06c},
      '{12'h058, 12'h060, 12'h068, 12'h070}
   };

   localparam logic [31:0] WAKE_CAPABLE [4] = '{
      32'h8003fe1b, 32'h002001fc, 32'hec080000, 32'h0012007f
   };

   logic [31:0] pin_in   [NBANKS];
   logic [31:0] out_lvl  [NBANKS];
   logic [31:0] dir_bits [NBANKS];
   logic [31:0] rise_en  [NBANKS];
   logic [31:0] fall_en  [NBANKS];
   logic [31:0] edge_st  [NBANKS];
   logic [31:0] last_drv [NBANKS];
   logic [31:0] alt_fn   [2*NBANKS];
   logic [7:0]  line_count;

   rsp_item_type expected_rsp_q [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic rsp_item_type predict_rsp(input req_item_type it);
      rsp_item_type r;
      reg_code_type code;
      int           bank;
      logic [31:0]  m;
      logic [31:0]  now_drv;
      logic [31:0]  other;
      logic         drives;
      r      = '0;
      code   = R_NONE;
      bank   = 0;
      drives = 1'b0;
      if ((it.req_type == REQ_READ || it.req_type == REQ_WRITE) &&
          it.offset < WINDOW_END) begin
         for (int row = 0; row < 9; row++)
            for (int b = 0; b < 4; b++)
               if (REG_OFFSETS[row][b] == it.offset) begin
                  code = reg_code_type'(row + 1);
                  bank = b;
               end
         if (code == R_NONE || bank >= NBANKS) begin
            r.bad_access = 1'b1;
         end else if (it.req_type == REQ_READ) begin
            case (code)
               R_LEVEL: r.rdata = (out_lvl[bank] & dir_bits[bank]) |
                                  (pin_in[bank] & ~dir_bits[bank]);
               R_DIR:   r.rdata = dir_bits[bank];
               R_RISE:  r.rdata = rise_en[bank];
               R_FALL:  r.rdata = fall_en[bank];
               R_EDGE:  r.rdata = edge_st[bank];
               R_AFL:   r.rdata = alt_fn[2*bank];
               R_AFU:   r.rdata = alt_fn[2*bank+1];
               default: r.bad_access = 1'b1;
            endcase
         end else begin
            case (code)
               R_DIR: begin
                  dir_bits[bank] = it.wdata;
                  drives = 1'b1;
               end
               R_SET: begin
                  out_lvl[bank] |= it.wdata;
                  drives = 1'b1;
               end
               R_CLR: begin
                  out_lvl[bank] &= ~it.wdata;
                  drives = 1'b1;
               end
               R_RISE:  rise_en[bank] = it.wdata;
               R_FALL:  fall_en[bank] = it.wdata;
               R_EDGE:  edge_st[bank] &= ~it.wdata;
               R_AFL:   alt_fn[2*bank] = it.wdata;
               R_AFU:   alt_fn[2*bank+1] = it.wdata;
               default: r.bad_access = 1'b1;
            endcase
            if (drives) begin
               now_drv         = out_lvl[bank] & dir_bits[bank];
               r.changed_bank  = 2'(bank);
               r.changed_mask  = last_drv[bank] ^ now_drv;
               r.driven_levels = now_drv;
               last_drv[bank]  = now_drv;
            end
         end
      end else if (it.req_type == REQ_EVENT) begin
         bank = int'(it.pin_line[6:5]);
         if ({1'b0, it.pin_line} >= line_count || bank >= NBANKS) begin
            r.bad_access = 1'b1;
         end else begin
            m = 32'd1 << it.pin_line[4:0];
            // Only input pins can see an edge; the level is stored anyway.
            if (it.pin_level) begin
               edge_st[bank] |= rise_en[bank] & m & ~pin_in[bank] & ~dir_bits[bank];
               pin_in[bank]  |= m;
            end else begin
               edge_st[bank] |= fall_en[bank] & m & pin_in[bank] & ~dir_bits[bank];
               pin_in[bank]  &= ~m;
            end
            if (it.cpu_halted && (m & ~dir_bits[bank] & WAKE_CAPABLE[bank]) != 0)
               r.wake_request = 1'b1;
         end
      end
      other = edge_st[0] & ~32'd3;
      for (int b = 1; b < NBANKS; b++)
         other |= edge_st[b];
      r.irq_pin0  = edge_st[0][0];
      r.irq_pin1  = edge_st[0][1];
      r.irq_other = |other;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : scoreboard
      req_item_type seen;
      rsp_item_type want;
      if (reset) begin
         foreach (pin_in[b]) begin
            pin_in[b]   = '0;
            out_lvl[b]  = '0;
            dir_bits[b] = '0;
            rise_en[b]  = '0;
            fall_en[b]  = '0;
            edge_st[b]  = '0;
            last_drv[b] = '0;
         end
         foreach (alt_fn[i])
            alt_fn[i] = '0;
         line_count = NUM_LINES_RESET;
         expected_rsp_q.delete();
      end else begin
         if (csr_if.valid && csr_if.ready)
            line_count = csr_if.data;

         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: response transaction with no request outstanding", $time);
               fail_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("rdata",         want.rdata,         rsp_if.rdata);
               check_field("bad_access",    want.bad_access,    rsp_if.bad_access);
               check_field("irq_pin0",      want.irq_pin0,      rsp_if.irq_pin0);
               check_field("irq_pin1",      want.irq_pin1,      rsp_if.irq_pin1);
               check_field("irq_other",     want.irq_other,     rsp_if.irq_other);
               check_field("wake_request",  want.wake_request,  rsp_if.wake_request);
               check_field("changed_bank",  want.changed_bank,  rsp_if.changed_bank);
               check_field("changed_mask",  want.changed_mask,  rsp_if.changed_mask);
               check_field("driven_levels", want.driven_levels, rsp_if.driven_levels);
            end
         end

         if (req_if.valid && req_if.ready) begin
            seen.req_type   = req_if.req_type;
            seen.offset     = req_if.offset;
            seen.wdata      = req_if.wdata;
            seen.pin_line   = req_if.pin_line;
            seen.pin_level  = req_if.pin_level;
            seen.cpu_halted = req_if.cpu_halted;
            expected_rsp_q.push_back(predict_rsp(seen));
         end
      end
      pending <= expected_rsp_q.size();
   end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: top-level testbench of the GPIO edge-detect controller
// Drives a directed opening sequence and then phases of random bus reads,
// bus writes and pin events under several line counts, with random gaps on
// the request side and random stalls on the response side. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
   import gpioed_pkg::*;

   // Request type 3 has no name in the package; the block must ignore it.
   localparam logic [1:0] REQ_IGNORED  = 2'd3;
   localparam int         CYCLE_LIMIT  = 600000;
   localparam int         RANDOM_ITEMS = 1550;
   localparam int         PHASES       = 8;

   logic       clock;
   logic       reset;
   int         pending;
   int         fail_count;
   int         cycles = 0;
   int         stall_left = 0;
   bit         quiet = 1'b0;
   logic [7:0] lines_now = NUM_LINES_RESET;

   gpioed_req_if req_ch ();
   gpioed_rsp_if rsp_ch ();
   gpioed_csr_if csr_ch ();

   gpio_controller_edge_detect DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   gpioed_checker CHECK (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_ch),
      .rsp_if     (rsp_ch),
      .csr_if     (csr_ch),
      .pending    (pending),
      .fail_count (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog. Even with the longest gaps and stalls, this limit is a wide
   // margin over the whole stimulus.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // Idle lengths: mostly none or short, now and then a long pause. In a
   // quiet phase both sides run flat out.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet)
         return 0;
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // Response side back-pressure. Ready rises after reset and then drops for
   // random stretches so that stalls land on every stage of the pipeline.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (!quiet && $urandom_range(0, 3) == 0)
            stall_left <= pick_gap();
      end
   end

   function automatic req_item_type make_req(input logic [1:0] kind,
                                             input logic [11:0] off,
                                             input logic [31:0] wd,
                                             input logic [6:0] line,
                                             input logic lvl, input logic halted);
      req_item_type it;
      it.req_type   = kind;
      it.offset     = off;
      it.wdata      = wd;
      it.pin_line   = line;
      it.pin_level  = lvl;
      it.cpu_halted = halted;
      return it;
   endfunction

   // Most offsets hit a decoded register; the rest probe holes, unaligned
   // addresses and the area above the register window.
   function automatic logic [11:0] pick_offset();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75)
         return ADDR_TABLE[$urandom_range(0, REG_ROWS-1)][$urandom_range(0, TABLE_BANKS-1)];
      if (r < 90)
         return 12'($urandom_range(0, 12'h1ff));
      return 12'($urandom);
   endfunction

   function automatic logic [31:0] pick_wdata();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return 32'd1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   // Pin numbers: anywhere, the lowest four pins (among them the two with their
   // own interrupt lines), or right around the current line count to hit the rejection boundary.
   function automatic logic [6:0] pick_line();
      int r;
      int v;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 7'($urandom);
      if (r < 75)
         return 7'($urandom_range(0, 3));
      v = int'(lines_now) + int'($urandom_range(0, 3)) - 2;
      if (v < 0)
         v = 0;
      if (v > 127)
         v = 127;
      return 7'(v);
   endfunction

   function automatic req_item_type random_req();
      req_item_type it;
      int r;
      r = $urandom_range(0, 99);
      it = make_req(REQ_READ, pick_offset(), pick_wdata(), pick_line(),
                    1'($urandom), 1'($urandom));
      if (r < 28)
         it.req_type = REQ_READ;
      else if (r < 58)
         it.req_type = REQ_WRITE;
      else if (r < 95)
         it.req_type = REQ_EVENT;
      else
         it.req_type = REQ_IGNORED;
      return it;
   endfunction

   // Present one request transaction and hold it until the block takes it.
   // Valid is only lowered when a gap actually follows, so back-to-back
   // transactions keep valid high without a glitch.
   task automatic send_req(input req_item_type it);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= it.req_type;
      req_ch.offset     <= it.offset;
      req_ch.wdata      <= it.wdata;
      req_ch.pin_line   <= it.pin_line;
      req_ch.pin_level  <= it.pin_level;
      req_ch.cpu_halted <= it.cpu_halted;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Wait for the pipeline to drain and let it settle, then write
   // the line-count register through its own channel.
   task automatic write_line_count(input logic [7:0] value);
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      lines_now = value;
   endtask

   initial begin
      logic [7:0] line_plan [PHASES];

      // Line counts per phase: the reset value first, then both extremes,
      // a single pin, bank edges, and one random count.
      line_plan = '{8'd128, 8'd0, 8'd255, 8'd1, 8'd64, 8'd127, 8'd33, 8'd128};
      line_plan[6] = 8'($urandom_range(2, 126));

      // Every request and configuration input gets a known value before the
      // first edge; response ready is held low by its own process in reset.
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= REQ_READ;
      req_ch.offset     <= '0;
      req_ch.wdata      <= '0;
      req_ch.pin_line   <= '0;
      req_ch.pin_level  <= 1'b0;
      req_ch.cpu_halted <= 1'b0;
      csr_ch.valid      <= 1'b0;
      csr_ch.data       <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed opening, with the reset line count of 128.
      // Level of bank 0 straight after reset reads as zero.
      send_req(make_req(REQ_READ, 12'h000, '0, 7'd0, 1'b0, 1'b0));
      // Upper half of bank 0 becomes output, then set and clear drive it,
      // each write reporting the bits whose driven level moved.
      send_req(make_req(REQ_WRITE, 12'h00c, 32'hffff0000, 7'd0, 1'b0, 1'b0));
      send_req(make_req(REQ_WRITE, 12'h018, 32'hffffffff, 7'd0, 1'b0, 1'b0));
      send_req(make_req(REQ_WRITE, 12'h024, 32'h0f0f0000, 7'd0, 1'b0, 1'b0));
      send_req(make_req(REQ_READ, 12'h000, '0, 7'd0, 1'b0, 1'b0));
      // Reading the set register and writing the level register are refused.
      send_req(make_req(REQ_READ, 12'h018, '0, 7'd0, 1'b0, 1'b0));
      send_req(make_req(REQ_WRITE, 12'h000, 32'hffffffff, 7'd0, 1'b0, 1'b0));
      // A hole in the decode table is flagged; above the window nothing is.
      send_req(make_req(REQ_WRITE, 12'h074, 32'hffffffff, 7'd0, 1'b0, 1'b0));
      send_req(make_req(REQ_READ, 12'hffc, '0, 7'd0, 1'b0, 1'b0));
      // Edge enables on banks 0 and 3, then edges on pins 0, 1 and 127.
      send_req(make_req(REQ_WRITE, 12'h030, 32'hffffffff, 7'd0, 1'b0, 1'b0));
      send_req(make_req(REQ_WRITE, 12'h03c, 32'hffffffff, 7'd0, 1'b0, 1'b0));
      send_req(make_req(REQ_WRITE, 12'h130, 32'hffffffff, 7'd0, 1'b0, 1'b0));
      send_req(make_req(REQ_EVENT, 12'h000, '0, 7'd0, 1'b1, 1'b1));
      send_req(make_req(REQ_EVENT, 12'h000, '0, 7'd1, 1'b1, 1'b0));
      send_req(make_req(REQ_EVENT, 12'h000, '0, 7'd1, 1'b0, 1'b0));
      send_req(make_req(REQ_EVENT, 12'h000, '0, 7'd127, 1'b1, 1'b1));
      // A wake-capable pin in bank 3 while halted, with its rising-edge enable set.
      send_req(make_req(REQ_EVENT, 12'h000, '0, 7'd96, 1'b1, 1'b1));
      // An event on a driven output pin must not latch an edge.
      send_req(make_req(REQ_EVENT, 12'h000, '0, 7'd31, 1'b1, 1'b1));
      // Read and clear the edge status, write one to clear.
      send_req(make_req(REQ_READ, 12'h048, '0, 7'd0, 1'b0, 1'b0));
      send_req(make_req(REQ_WRITE, 12'h048, 32'hffffffff, 7'd0, 1'b0, 1'b0));
      send_req(make_req(REQ_WRITE, 12'h148, 32'hffffffff, 7'd0, 1'b0, 1'b0));
      // Alternate-function words round trip.
      send_req(make_req(REQ_WRITE, 12'h064, 32'ha5a5a5a5, 7'd0, 1'b0, 1'b0));
      send_req(make_req(REQ_READ, 12'h064, '0, 7'd0, 1'b0, 1'b0));
      send_req(make_req(REQ_WRITE, 12'h070, 32'hffffffff, 7'd0, 1'b0, 1'b0));
      // The unused request type, then all of bank 0 back to input.
      send_req(make_req(REQ_IGNORED, 12'h00c, 32'hffffffff, 7'd0, 1'b1, 1'b1));
      send_req(make_req(REQ_WRITE, 12'h00c, 32'h00000000, 7'd0, 1'b0, 1'b0));

      // Random phases. Every third phase runs without any idling so that
      // back-to-back transactions stress the full throughput.
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0)
            write_line_count(line_plan[ph]);
         quiet <= (ph % 3 == 1);
         repeat (RANDOM_ITEMS / PHASES) send_req(random_req());
      end

      // Drain: every prediction must be matched, then a short settle.
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
